/* sv/bvm_pkg.sv */
// Shared types and constants for the battery voltage monitor.
// No dependencies; imported by the core and by its port checker.
package bvm_pkg;

    // Field widths
    localparam int ADC_W   = 12;
    localparam int MV_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Default build parameters
    localparam int WINDOW_DEF         = 8;
    localparam int ADC_FULL_SCALE_DEF = 4096;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE = 2'd0,
        CFG_MIN_THRESH = 2'd1,
        CFG_MAX_THRESH = 2'd2
    } cfg_index_t;

    // Register reset values
    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd30000;
    localparam logic [CFG_W-1:0] MIN_THRESH_RST = 16'd0;
    localparam logic [CFG_W-1:0] MAX_THRESH_RST = 16'hFFFF;

    localparam logic [MV_W-1:0] MV_MAX = '1;

endpackage

/* sv/battery_voltage_monitor_core.sv */
// Steps from input accept to result valid: 2 multiply stages, ring read, commit,
// average multiply. Throughput: one item per cycle; the whole pipeline
// stalls only while the output register holds a result that is not taken.
// The sample ring is a synchronous memory, read into a register ahead of the commit stage.
// Reset (rst_n low, async) clears pipeline valids, pointer, fill count, sum, alarms
// and loads the register defaults; ring contents are not cleared (read data used only once full).
// Battery voltage monitor core: scaling, moving-average ring and threshold alarms.
// Depends on bvm_pkg.
module battery_voltage_monitor_core
    import bvm_pkg::*;
#(
    parameter int WINDOW         = WINDOW_DEF,
    parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADC_W-1:0]     adc_sample,
    input  logic                 sample_ok,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MV_W-1:0]      inst_mv,
    output logic [MV_W-1:0]      avg_mv,
    output logic                 voltage_valid,
    output logic                 over_alarm,
    output logic                 under_alarm,
    output logic                 over_event,
    output logic                 under_event
);

    // Derived sizes
    localparam int PTR_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SUM_W   = MV_W + $clog2(WINDOW);
    localparam int PROD_W  = ADC_W + MV_W;

    // Scale divide: floor(p / ADC_FULL_SCALE) = (p * SC_RECIP) >> SC_SHIFT, exact for p < 2^PROD_W
    localparam int SC_SHIFT   = PROD_W + $clog2(ADC_FULL_SCALE);
    localparam int SC_RECIP_W = PROD_W + 1;
    localparam int SC_QM_W    = PROD_W + SC_RECIP_W;
    localparam longint unsigned SC_RECIP_L =
        ((64'd1 << SC_SHIFT) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
    localparam logic [SC_RECIP_W-1:0] SC_RECIP = SC_RECIP_W'(SC_RECIP_L);

    // Mean divide: floor(s / WINDOW) = (s * AV_RECIP) >> AV_SHIFT, exact for s < 2^SUM_W
    localparam int AV_SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int AV_RECIP_W = SUM_W + 1;
    localparam int AV_QM_W    = SUM_W + AV_RECIP_W;
    localparam longint unsigned AV_RECIP_L =
        ((64'd1 << AV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [AV_RECIP_W-1:0] AV_RECIP = AV_RECIP_W'(AV_RECIP_L);

    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW - 1);

    // Configuration registers
    logic [CFG_W-1:0] full_scale_reg;
    logic [CFG_W-1:0] min_thresh_reg;
    logic [CFG_W-1:0] max_thresh_reg;

    // Pipeline control
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic ok1_reg, ok2_reg, ok3_reg;

    // Stage payloads
    logic [PROD_W-1:0]  prod1_reg;
    logic [SC_QM_W-1:0] qm2_reg;
    logic [MV_W-1:0]    inst3_reg;
    logic [MV_W-1:0]    rd_data_reg;

    logic [MV_W-1:0]  inst4_reg;
    logic [SUM_W-1:0] sum4_reg;
    logic             full4_reg;
    logic             valid4_reg;
    logic             over4_reg, under4_reg, over_ev4_reg, under_ev4_reg;

    logic [MV_W-1:0]  inst_out_reg;
    logic [MV_W-1:0]  avg_out_reg;
    logic             valid_out_reg;
    logic             over_out_reg, under_out_reg, over_ev_out_reg, under_ev_out_reg;

    // Ring state
    logic [MV_W-1:0]  ring_mem [WINDOW];
    logic [PTR_W-1:0] wp_reg, wp_next, wp_inc, rd_addr;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             over_reg, over_next, under_reg, under_next;
    logic             commit_ok, full_now;

    // Scale result from stage 2
    logic [SC_QM_W-1:0] q_full;
    logic [PROD_W-1:0]  q_mv;
    logic [MV_W-1:0]    inst_sat;

    // Mean result from stage 4
    logic [AV_QM_W-1:0] avg_qm;
    logic [AV_QM_W-1:0] avg_full;

    // Whole pipeline moves when the output register is free or being taken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FULL_SCALE_RST;
            min_thresh_reg <= MIN_THRESH_RST;
            max_thresh_reg <= MAX_THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                CFG_MIN_THRESH: min_thresh_reg <= cfg_wdata;
                CFG_MAX_THRESH: max_thresh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Scale: sample x full-scale, then reciprocal multiply, then shift and saturate
    assign q_full   = qm2_reg >> SC_SHIFT;
    assign q_mv     = q_full[PROD_W-1:0];
    assign inst_sat = (q_mv[PROD_W-1:MV_W] != '0) ? MV_MAX : q_mv[MV_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= PROD_W'(adc_sample) * PROD_W'(full_scale_reg);
            ok1_reg   <= sample_ok;
            qm2_reg   <= SC_QM_W'(prod1_reg) * SC_QM_W'(SC_RECIP);
            ok2_reg   <= ok1_reg;
            inst3_reg <= inst_sat;
            ok3_reg   <= ok2_reg;
        end
    end

    // Read address for the item entering stage 3 accounts for the commit in flight
    assign wp_inc  = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rd_addr = (v3_reg && ok3_reg) ? wp_inc : wp_reg;

    // Ring memory: one write port at the pointer, one registered read port
    always_ff @(posedge clk)
    begin
        if (en && commit_ok)
        begin
            ring_mem[wp_reg] <= inst3_reg;
        end
        if (en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Commit: sum update, pointer, fill and alarms
    assign commit_ok = v3_reg && ok3_reg;
    assign full_now  = (fill_reg == FILL_FULL);

    always_comb
    begin
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        over_next  = over_reg;
        under_next = under_reg;
        if (commit_ok)
        begin
            sum_next   = sum_reg - (full_now ? SUM_W'(rd_data_reg) : '0)
                         + SUM_W'(inst3_reg);
            fill_next  = full_now ? fill_reg : fill_reg + 1'b1;
            wp_next    = wp_inc;
            over_next  = inst3_reg > max_thresh_reg;
            under_next = inst3_reg < min_thresh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            over_reg  <= 1'b0;
            under_reg <= 1'b0;
        end
        else if (en && v3_reg)
        begin
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            over_reg  <= over_next;
            under_reg <= under_next;
        end
    end

    // Stage 4: result fields except the mean
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inst4_reg     <= ok3_reg ? inst3_reg : '0;
            sum4_reg      <= sum_next;
            full4_reg     <= (fill_next == FILL_FULL);
            valid4_reg    <= ok3_reg && (fill_next == FILL_FULL) && !over_next && !under_next;
            over4_reg     <= over_next;
            under4_reg    <= under_next;
            over_ev4_reg  <= commit_ok && over_next && !over_reg;
            under_ev4_reg <= commit_ok && under_next && !under_reg;
        end
    end

    // Mean by reciprocal multiply
    assign avg_qm   = AV_QM_W'(sum4_reg) * AV_QM_W'(AV_RECIP);
    assign avg_full = avg_qm >> AV_SHIFT;

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inst_out_reg     <= inst4_reg;
            avg_out_reg      <= full4_reg ? avg_full[MV_W-1:0] : '0;
            valid_out_reg    <= valid4_reg;
            over_out_reg     <= over4_reg;
            under_out_reg    <= under4_reg;
            over_ev_out_reg  <= over_ev4_reg;
            under_ev_out_reg <= under_ev4_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign inst_mv       = inst_out_reg;
    assign avg_mv        = avg_out_reg;
    assign voltage_valid = valid_out_reg;
    assign over_alarm    = over_out_reg;
    assign under_alarm   = under_out_reg;
    assign over_event    = over_ev_out_reg;
    assign under_event   = under_ev_out_reg;

endmodule

/* sv/bvm_checker.sv */
// Port-level checks for the battery voltage monitor core, bound to the core module.
// Depends on bvm_pkg.
module bvm_checker
    import bvm_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input logic [MV_W-1:0] inst_mv,
    input logic [MV_W-1:0] avg_mv,
    input logic            voltage_valid,
    input logic            over_alarm,
    input logic            under_alarm,
    input logic            over_event,
    input logic            under_event
);

    // A stalled result stays valid and holds its voltages
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inst_mv) && $stable(avg_mv))
        else $error("result changed while stalled");

    // An event is only raised together with its alarm
    a_over_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && over_event |-> over_alarm)
        else $error("over event without over alarm");

    a_under_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && under_event |-> under_alarm)
        else $error("under event without under alarm");

    // A valid voltage excludes both alarms
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && voltage_valid |-> !over_alarm && !under_alarm)
        else $error("voltage valid with alarm set");

endmodule

bind battery_voltage_monitor_core bvm_checker u_bvm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .inst_mv       (inst_mv),
    .avg_mv        (avg_mv),
    .voltage_valid (voltage_valid),
    .over_alarm    (over_alarm),
    .under_alarm   (under_alarm),
    .over_event    (over_event),
    .under_event   (under_event)
);
